/* hw/rtl/bssc_pkg.sv */
// Shared types, constants and lookup functions for the six-step commutator.
`timescale 1ns / 1ps

package bssc_pkg;

   localparam int SAMPLE_BITS = 10;
   localparam int DUTY_W      = 8;
   localparam int HALL_W      = 3;
   localparam int STEP_W      = 3;
   localparam int PROD_W      = SAMPLE_BITS + DUTY_W;
   localparam int CSR_IDX_W   = 2;

   localparam logic [DUTY_W-1:0] MAX_DUTY_RST  = 8'd200;
   localparam logic [DUTY_W-1:0] DEAD_TIME_RST = 8'd21;
   localparam logic [DUTY_W-1:0] ARM_THR_RST   = 8'd40;

   localparam logic [CSR_IDX_W-1:0] REG_MAX_DUTY  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DEAD_TIME = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ARM_THR   = 2'd2;

   localparam logic [STEP_W-1:0] STEP_NONE = 3'd0;
   localparam logic [STEP_W-1:0] STEP_1    = 3'd1;
   localparam logic [STEP_W-1:0] STEP_2    = 3'd2;
   localparam logic [STEP_W-1:0] STEP_3    = 3'd3;
   localparam logic [STEP_W-1:0] STEP_4    = 3'd4;
   localparam logic [STEP_W-1:0] STEP_5    = 3'd5;
   localparam logic [STEP_W-1:0] STEP_6    = 3'd6;

   typedef enum logic [1:0] {
      MODE_OFF = 2'd0,
      MODE_LOW = 2'd1,
      MODE_PWM = 2'd2
   } mode_type;

   typedef struct packed {
      mode_type a;
      mode_type b;
      mode_type c;
   } phase_set_type;

   typedef struct packed {
      logic [DUTY_W-1:0] max_duty;
      logic [DUTY_W-1:0] dead_time;
      logic [DUTY_W-1:0] arm_threshold;
   } cfg_type;

   typedef struct packed {
      logic [HALL_W-1:0] hall;
      logic [PROD_W-1:0] product;
   } prod_type;

   typedef struct packed {
      logic [STEP_W-1:0] step_in_use;
      logic [DUTY_W-1:0] duty;
      logic              armed;
      phase_set_type     phases;
      logic [DUTY_W-1:0] high_compare;
      logic [DUTY_W-1:0] low_compare;
   } rsp_type;

   function automatic logic [STEP_W-1:0] hall_to_step(input logic [HALL_W-1:0] hall);
      logic [STEP_W-1:0] step;
      case (hall)
         3'd5:    step = STEP_1;
         3'd1:    step = STEP_2;
         3'd3:    step = STEP_3;
         3'd2:    step = STEP_4;
         3'd6:    step = STEP_5;
         3'd4:    step = STEP_6;
         default: step = STEP_NONE;
      endcase
      return step;
   endfunction

   function automatic phase_set_type step_modes(input logic [STEP_W-1:0] step);
      phase_set_type m;
      case (step)
         STEP_1:  m = '{MODE_LOW, MODE_PWM, MODE_OFF};
         STEP_2:  m = '{MODE_LOW, MODE_OFF, MODE_PWM};
         STEP_3:  m = '{MODE_OFF, MODE_LOW, MODE_PWM};
         STEP_4:  m = '{MODE_PWM, MODE_LOW, MODE_OFF};
         STEP_5:  m = '{MODE_PWM, MODE_OFF, MODE_LOW};
         STEP_6:  m = '{MODE_OFF, MODE_PWM, MODE_LOW};
         default: m = '{MODE_OFF, MODE_OFF, MODE_OFF};
      endcase
      return m;
   endfunction

endpackage

/* hw/rtl/bssc_csr.sv */
// Configuration register file: max duty, dead time and arm threshold.
`timescale 1ns / 1ps

module bssc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bssc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bssc_pkg::DUTY_W-1:0]       csr_data,
   output bssc_pkg::cfg_type                 cfg
);
   import bssc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_MAX_DUTY:  cfg_in.max_duty      = csr_data;
            REG_DEAD_TIME: cfg_in.dead_time     = csr_data;
            REG_ARM_THR:   cfg_in.arm_threshold = csr_data;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_duty      <= MAX_DUTY_RST;
         cfg_ff.dead_time     <= DEAD_TIME_RST;
         cfg_ff.arm_threshold <= ARM_THR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* hw/rtl/bssc_scale.sv */
// Input register and throttle-times-max-duty product stage.
`timescale 1ns / 1ps

module bssc_scale (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [bssc_pkg::HALL_W-1:0]        in_hall,
   input  logic [bssc_pkg::SAMPLE_BITS-1:0]   in_sample,
   input  logic [bssc_pkg::DUTY_W-1:0]        max_duty,
   output logic                               out_valid,
   input  logic                               out_ready,
   output bssc_pkg::prod_type                 out_data
);
   import bssc_pkg::*;

   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [HALL_W-1:0]      hall_ff;
   logic [HALL_W-1:0]      hall_in;
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic [SAMPLE_BITS-1:0] sample_in;
   logic                   prod_valid_ff;
   logic                   prod_valid_in;
   prod_type               prod_ff;
   prod_type               prod_in;
   logic                   prod_take;
   logic                   in_take;

   assign prod_take = !prod_valid_ff || out_ready;
   assign in_take   = !in_valid_ff || prod_take;
   assign in_ready  = in_take;
   assign out_valid = prod_valid_ff;
   assign out_data  = prod_ff;

   always_comb begin
      in_valid_in   = in_take ? in_valid : in_valid_ff;
      hall_in       = (in_take && in_valid) ? in_hall : hall_ff;
      sample_in     = (in_take && in_valid) ? in_sample : sample_ff;
      prod_valid_in = prod_take ? in_valid_ff : prod_valid_ff;
      prod_in       = prod_ff;
      if (prod_take && in_valid_ff) begin
         prod_in.hall    = hall_ff;
         prod_in.product = PROD_W'(sample_ff) * PROD_W'(max_duty);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         prod_valid_ff <= prod_valid_in;
      end
      hall_ff   <= hall_in;
      sample_ff <= sample_in;
      prod_ff   <= prod_in;
   end

endmodule

/* hw/rtl/bssc_drive.sv */
// Duty division, step latch, arming interlock, step table and result register.
`timescale 1ns / 1ps

module bssc_drive (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  bssc_pkg::prod_type  in_data,
   input  bssc_pkg::cfg_type   cfg,
   output logic                out_valid,
   input  logic                out_ready,
   output bssc_pkg::rsp_type   out_data
);
   import bssc_pkg::*;

   localparam int QSUM_W = PROD_W + 1;

   logic              latched_ff;
   logic              latched_in;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              released_ff;
   logic              released_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;

   logic              take;
   logic              fire;
   logic [QSUM_W-1:0] qsum;
   logic [DUTY_W-1:0] duty;
   logic [STEP_W-1:0] dec_step;
   logic [STEP_W-1:0] step_now;
   logic              released_now;
   logic              active;
   logic [DUTY_W:0]   lo_sum;

   assign take      = !rsp_valid_ff || out_ready;
   assign fire      = take && in_valid;
   assign in_ready  = take;
   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

   always_comb begin
      // floor(x / (2^S - 1)) as (x + (x >> S) + 1) >> S, exact while quotient < 2^S
      qsum = QSUM_W'(in_data.product) + QSUM_W'(in_data.product >> SAMPLE_BITS)
           + QSUM_W'(1);
      duty = qsum[SAMPLE_BITS +: DUTY_W];

      dec_step     = hall_to_step(in_data.hall);
      step_now     = (dec_step != STEP_NONE) ? dec_step : step_ff;
      released_now = released_ff || (duty < cfg.arm_threshold);
      active       = released_now && (duty != '0) && (step_now != STEP_NONE);
      lo_sum       = {1'b0, duty} + {1'b0, cfg.dead_time};

      latched_in   = fire ? (latched_ff || (step_now != STEP_NONE)) : latched_ff;
      step_in      = fire ? step_now : step_ff;
      released_in  = fire ? released_now : released_ff;
      rsp_valid_in = take ? in_valid : rsp_valid_ff;

      rsp_in = rsp_ff;
      if (fire) begin
         rsp_in.step_in_use  = step_now;
         rsp_in.duty         = duty;
         rsp_in.armed        = released_now;
         rsp_in.phases       = step_modes(active ? step_now : STEP_NONE);
         rsp_in.high_compare = active ? duty : '0;
         rsp_in.low_compare  = !active ? '0 :
                               (lo_sum[DUTY_W] ? {DUTY_W{1'b1}} : lo_sum[DUTY_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latched_ff   <= 1'b0;
         step_ff      <= STEP_NONE;
         released_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         latched_ff   <= latched_in;
         step_ff      <= step_in;
         released_ff  <= released_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

`ifndef ASSERT_OFF
   a_armed_sticks: assert property (@(posedge clock) disable iff (reset)
      released_ff |=> released_ff)
      else $error("interlock dropped after release");

   a_step_sticks: assert property (@(posedge clock) disable iff (reset)
      (step_ff != STEP_NONE) |=> (step_ff != STEP_NONE))
      else $error("latched step returned to none");

   a_step_flag: assert property (@(posedge clock) disable iff (reset)
      latched_ff == (step_ff != STEP_NONE))
      else $error("step latch flag out of sync with latched step");

   a_off_unarmed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.armed) |->
         (rsp_ff.phases.a == MODE_OFF && rsp_ff.phases.b == MODE_OFF &&
          rsp_ff.phases.c == MODE_OFF && rsp_ff.high_compare == '0))
      else $error("phase driven before arming");

   a_one_pwm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($countones({rsp_ff.phases.a == MODE_PWM, rsp_ff.phases.b == MODE_PWM,
                                    rsp_ff.phases.c == MODE_PWM}) <= 1))
      else $error("more than one phase on PWM");
`endif

endmodule

/* hw/rtl/bldc_six_step_commutator.sv */
// Top level of the hall-sensor six-step commutator.
`timescale 1ns / 1ps

// Takes one hall/throttle transfer per clock and returns one result transfer per item,
// passing through the input register, product register and result register;
// sustained throughput is one item every cycle, limited only by rsp_tready backpressure.
// Duty is floor(throttle * max_duty / 1023) from one 10x8 multiply and a constant-divisor
// add-and-shift; phases stay off until duty first drops below arm_threshold, then the
// six-step table drives each phase off, low side on, or PWM with duty-based compares.

module bldc_six_step_commutator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // hall_bits[2:0], throttle_sample[12:3], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,    // step_in_use[2:0], duty[10:3], armed[11],
                                     // phase_a_mode[13:12], phase_b_mode[15:14],
                                     // phase_c_mode[17:16], high_compare[25:18],
                                     // low_compare[33:26], zero fill
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import bssc_pkg::*;

   localparam int RSP_W = $bits(rsp_type);

   cfg_type  cfg;
   prod_type prod;
   rsp_type  rsp;
   logic     prod_valid;
   logic     prod_ready;

   bssc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bssc_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_hall   (req_tdata[HALL_W-1:0]),
      .in_sample (req_tdata[HALL_W +: SAMPLE_BITS]),
      .max_duty  (cfg.max_duty),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_data  (prod)
   );

   bssc_drive u_drive (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .in_data   (prod),
      .cfg       (cfg),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp)
   );

   assign rsp_tdata = {{(40 - RSP_W){1'b0}},
                       rsp.low_compare,
                       rsp.high_compare,
                       rsp.phases.c,
                       rsp.phases.b,
                       rsp.phases.a,
                       rsp.armed,
                       rsp.duty,
                       rsp.step_in_use};

endmodule

/* tb/bldc_six_step_commutator_checker.sv */
// Checker that predicts and compares every result transfer of the six-step commutator.
`timescale 1ns / 1ps

module bldc_six_step_commutator_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [15:0]                    req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [39:0]                    rsp_tdata,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [bssc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                     csr_data,
   output int                             open_results,
   output int                             mismatch_count
);
   import bssc_pkg::*;

   localparam int unsigned FULL_SCALE  = (1 << SAMPLE_BITS) - 1;
   localparam int unsigned COMPARE_TOP = (1 << DUTY_W) - 1;
   localparam int          REPORT_MAX  = 10;

   typedef struct packed {
      logic [STEP_W-1:0] comm_step;
      logic [DUTY_W-1:0] duty;
      logic              armed;
      mode_type          phase_a;
      mode_type          phase_b;
      mode_type          phase_c;
      logic [DUTY_W-1:0] high_cmp;
      logic [DUTY_W-1:0] low_cmp;
   } drive_word_type;

   logic [DUTY_W-1:0] max_duty_q;
   logic [DUTY_W-1:0] dead_time_q;
   logic [DUTY_W-1:0] arm_thr_q;
   logic [STEP_W-1:0] held_step;
   logic              released;
   drive_word_type    drive_queue[$];
   drive_word_type    got;
   drive_word_type    want;
   int                outstanding = 0;
   int                failures = 0;

   assign open_results   = outstanding;
   assign mismatch_count = failures;

   function automatic drive_word_type commutate(input logic [HALL_W-1:0] hall,
                                                input logic [SAMPLE_BITS-1:0] throttle);
      drive_word_type    r;
      logic [STEP_W-1:0] decoded;
      int unsigned       scaled;
      int unsigned       widened;
      case (hall)
         3'd5:    decoded = STEP_1;
         3'd1:    decoded = STEP_2;
         3'd3:    decoded = STEP_3;
         3'd2:    decoded = STEP_4;
         3'd6:    decoded = STEP_5;
         3'd4:    decoded = STEP_6;
         default: decoded = STEP_NONE;
      endcase
      if (decoded != STEP_NONE) held_step = decoded;
      scaled = 32'(throttle);
      scaled = scaled * 32'(max_duty_q);
      scaled = scaled / FULL_SCALE;
      if (scaled > 32'(max_duty_q)) scaled = 32'(max_duty_q);
      r = '0;
      r.comm_step = held_step;
      r.duty      = scaled[DUTY_W-1:0];
      if (r.duty < arm_thr_q) released = 1'b1;
      r.armed   = released;
      r.phase_a = MODE_OFF;
      r.phase_b = MODE_OFF;
      r.phase_c = MODE_OFF;
      if (released && r.duty != '0 && held_step != STEP_NONE) begin
         widened    = 32'(r.duty);
         widened    = widened + 32'(dead_time_q);
         r.high_cmp = r.duty;
         r.low_cmp  = (widened > COMPARE_TOP) ? COMPARE_TOP[DUTY_W-1:0] : widened[DUTY_W-1:0];
         case (held_step)
            STEP_1: begin
               r.phase_a = MODE_LOW;
               r.phase_b = MODE_PWM;
            end
            STEP_2: begin
               r.phase_a = MODE_LOW;
               r.phase_c = MODE_PWM;
            end
            STEP_3: begin
               r.phase_b = MODE_LOW;
               r.phase_c = MODE_PWM;
            end
            STEP_4: begin
               r.phase_a = MODE_PWM;
               r.phase_b = MODE_LOW;
            end
            STEP_5: begin
               r.phase_a = MODE_PWM;
               r.phase_c = MODE_LOW;
            end
            STEP_6: begin
               r.phase_b = MODE_PWM;
               r.phase_c = MODE_LOW;
            end
            default: ;
         endcase
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         max_duty_q  = MAX_DUTY_RST;
         dead_time_q = DEAD_TIME_RST;
         arm_thr_q   = ARM_THR_RST;
         held_step   = STEP_NONE;
         released    = 1'b0;
         drive_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.comm_step = rsp_tdata[2:0];
            got.duty      = rsp_tdata[10:3];
            got.armed     = rsp_tdata[11];
            got.phase_a   = mode_type'(rsp_tdata[13:12]);
            got.phase_b   = mode_type'(rsp_tdata[15:14]);
            got.phase_c   = mode_type'(rsp_tdata[17:16]);
            got.high_cmp  = rsp_tdata[25:18];
            got.low_cmp   = rsp_tdata[33:26];
            if (drive_queue.size() == 0) begin
               if (failures < REPORT_MAX)
                  $display("%0t: result transfer with no prediction pending, data %h",
                           $time, rsp_tdata);
               failures++;
            end else begin
               want = drive_queue.pop_front();
               if (got.comm_step != want.comm_step || got.duty != want.duty ||
                   got.armed != want.armed || got.phase_a != want.phase_a ||
                   got.phase_b != want.phase_b || got.phase_c != want.phase_c ||
                   got.high_cmp != want.high_cmp || got.low_cmp != want.low_cmp) begin
                  if (failures < REPORT_MAX) begin
                     $display(
                        "%0t: expected step %0d duty %0d armed %0d modes %0d %0d %0d cmp %0d %0d",
                        $time, want.comm_step, want.duty, want.armed, want.phase_a,
                        want.phase_b, want.phase_c, want.high_cmp, want.low_cmp);
                     $display(
                        "%0t:   actual step %0d duty %0d armed %0d modes %0d %0d %0d cmp %0d %0d",
                        $time, got.comm_step, got.duty, got.armed, got.phase_a,
                        got.phase_b, got.phase_c, got.high_cmp, got.low_cmp);
                  end
                  failures++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MAX_DUTY:  max_duty_q  = csr_data;
               REG_DEAD_TIME: dead_time_q = csr_data;
               REG_ARM_THR:   arm_thr_q   = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            drive_queue.push_back(commutate(req_tdata[HALL_W-1:0],
                                            req_tdata[HALL_W +: SAMPLE_BITS]));
      end
      outstanding = drive_queue.size();
   end

endmodule

/* tb/bldc_six_step_commutator_tb.sv */
// Stimulus, clock, reset and verdict for the six-step commutator testbench.
`timescale 1ns / 1ps

module bldc_six_step_commutator_tb;
   import bssc_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int BATCHES        = 15;
   localparam int BATCH_ITEMS    = 110;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [15:0]          req_tdata;     // hall_bits[2:0], throttle_sample[12:3], zero fill
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [39:0]          rsp_tdata;     // step_in_use[2:0], duty[10:3], armed[11],
                                        // phase_a_mode[13:12], phase_b_mode[15:14],
                                        // phase_c_mode[17:16], high_compare[25:18],
                                        // low_compare[33:26], zero fill
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [7:0]           csr_data;
   int                   open_results;
   int                   mismatch_count;
   int                   source_idle_pct;
   int                   sink_idle_pct;
   int                   quiet_cycles = 0;

   bldc_six_step_commutator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   bldc_six_step_commutator_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .open_results   (open_results),
      .mismatch_count (mismatch_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= sink_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Drop the request and hold until every predicted result has been taken.
   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      while (open_results != 0) @(negedge clock);
   endtask

   // Leaves req_tvalid high; the next call or a drain decides what follows.
   task automatic push_sample(input logic [HALL_W-1:0] hall,
                              input logic [SAMPLE_BITS-1:0] throttle);
      csr_valid <= 1'b0;
      while ($urandom_range(99) < source_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(16 - HALL_W - SAMPLE_BITS){1'b0}}, throttle, hall};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic apply_setting(input logic [7:0] full_scale, input logic [7:0] dead,
                                input logic [7:0] threshold);
      logic [CSR_IDX_W-1:0] reg_index [4];
      logic [7:0]           reg_value [4];
      reg_index[0] = REG_MAX_DUTY;
      reg_index[1] = REG_DEAD_TIME;
      reg_index[2] = REG_ARM_THR;
      reg_index[3] = REG_SPARE;
      reg_value[0] = full_scale;
      reg_value[1] = dead;
      reg_value[2] = threshold;
      reg_value[3] = 8'($urandom_range(255));
      hold_until_drained();
      for (int k = 0; k < 4; k++) begin
         csr_valid <= 1'b1;
         csr_index <= reg_index[k];
         csr_data  <= reg_value[k];
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [HALL_W-1:0]      hall_pick;
      logic [SAMPLE_BITS-1:0] throttle_pick;
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      csr_valid       = 1'b0;
      csr_index       = REG_MAX_DUTY;
      csr_data        = '0;
      source_idle_pct = 14;
      sink_idle_pct   = 74;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: high throttle keeps the interlock closed
      push_sample(3'd5, 10'd1023);
      push_sample(3'd0, 10'd512);

      // zero threshold never releases
      apply_setting(8'd255, 8'd255, 8'd0);
      push_sample(3'd7, 10'd0);
      push_sample(3'd3, 10'd1023);
      push_sample(3'd6, 10'd0);

      // release on low throttle, zero duty, saturated low compare, invalid halls
      apply_setting(8'd255, 8'd255, ARM_THR_RST);
      push_sample(3'd1, 10'd1023);
      push_sample(3'd4, 10'd100);
      push_sample(3'd4, 10'd0);
      push_sample(3'd2, 10'd4);
      push_sample(3'd2, 10'd5);
      push_sample(3'd7, 10'd5);
      push_sample(3'd0, 10'd1023);

      // every step, zero dead time
      apply_setting(MAX_DUTY_RST, 8'd0, 8'd255);
      push_sample(3'd5, 10'd512);
      push_sample(3'd1, 10'd256);
      push_sample(3'd3, 10'd768);
      push_sample(3'd2, 10'd1000);
      push_sample(3'd6, 10'd1);
      push_sample(3'd4, 10'd1023);

      apply_setting(8'd1, DEAD_TIME_RST, ARM_THR_RST);
      push_sample(3'd6, 10'd1022);
      push_sample(3'd6, 10'd1023);

      apply_setting(8'd0, 8'd10, ARM_THR_RST);
      push_sample(3'd5, 10'd1023);

      for (int b = 0; b < BATCHES; b++) begin
         if (b == BATCHES / 3) begin
            source_idle_pct = 74;
            sink_idle_pct   = 14;
         end
         if (b == 2 * BATCHES / 3) begin
            source_idle_pct = 0;
            sink_idle_pct   = 0;
         end
         case (b % 5)
            0: apply_setting(8'($urandom_range(1, 255)), 8'($urandom_range(255)),
                             8'($urandom_range(255)));
            1: apply_setting(8'd255, 8'd255, 8'd255);
            2: apply_setting(8'd1, 8'd0, 8'd0);
            3: apply_setting(MAX_DUTY_RST, DEAD_TIME_RST, ARM_THR_RST);
            default: apply_setting(8'($urandom_range(100, 255)), 8'($urandom_range(40)),
                                   8'($urandom_range(1, 255)));
         endcase
         repeat (BATCH_ITEMS) begin
            hall_pick = HALL_W'($urandom_range(7));
            case ($urandom_range(9))
               0:       throttle_pick = SAMPLE_BITS'($urandom_range(15));
               1:       throttle_pick = SAMPLE_BITS'(1023 - $urandom_range(15));
               default: throttle_pick = SAMPLE_BITS'($urandom_range(1023));
            endcase
            if ($urandom_range(199) == 0) hold_until_drained();
            push_sample(hall_pick, throttle_pick);
         end
      end

      hold_until_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && open_results == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
